/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the hex digit helper function of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS = 25;
    localparam logic [15:0] RESET_BLANK = 16'h0F20;
    localparam int LEFT_W = 5;
    localparam logic [LEFT_W-1:0] HEX_LEN = 5'd18;
    localparam logic [LEFT_W-1:0] HEX_DIGITS = 5'd16;
    localparam logic [LEFT_W-1:0] DEC_MAX = 5'd10;
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X = 8'h78;
    localparam logic [7:0] CHAR_A = 8'h61;

    typedef enum logic [2:0] {
        FUNC_PUT   = 3'd0,
        FUNC_NL    = 3'd1,
        FUNC_CLEAR = 3'd2,
        FUNC_READ  = 3'd3,
        FUNC_HEX   = 3'd4,
        FUNC_DEC   = 3'd5
    } t_func;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_NEXT,
        S_NL,
        S_CLEAR,
        S_READ,
        S_DIV_MUL,
        S_DIV_SUB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_CLEAR,
        DP_PUT,
        DP_SCROLL,
        DP_NL,
        DP_READ,
        DP_DIV_MUL,
        DP_DIV_SUB,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic sweep_last;
        logic scroll_last;
        logic last_cell;
        logic last_row;
        logic chars_left;
        logic nl_pending;
        logic dec_done;
    } t_status;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = CHAR_ZERO + {4'b0, nib};
        end else begin
            hex_char = CHAR_A + {4'b0, nib - 4'd10};
        end
    endfunction

endpackage

/* design/text_console_writer_core.sv */
`timescale 1ns / 1ps
// Top level of the text console writer: controller, datapath and port checks.
// After reset the block fills all COLUMNS*ROWS cells with the reset blank word, one cell a
// cycle, before it takes its first word. A hex print writes 0x and then its digits, and a
// decimal print first splits off its digits through the reciprocal multiplier and then
// prints them. A put or a print may be followed by a newline. Every scroll has the cell
// memory copy one cell a cycle and then blank the last row one cell a cycle. The next
// word is taken while a result waits on o_valid.
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_attribute,
    input  logic [63:0] i_number,
    input  logic [10:0] i_read_index,
    input  logic        i_newline_after,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_word,
    output logic [10:0] o_cursor_pos,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_dp_op  op;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_stall  (i_stall),
        .i_status (status),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_op     (op)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_character     (i_character),
        .i_attribute     (i_attribute),
        .i_number        (i_number),
        .i_read_index    (i_read_index),
        .i_newline_after (i_newline_after),
        .o_status        (status),
        .o_read_word     (o_read_word),
        .o_cursor_pos    (o_cursor_pos)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a command is still in progress");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a command in progress");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_cursor_pos) < 32'(COLUMNS * ROWS)))
        else $error("cursor outside the cell buffer");

endmodule

/* design/tcw_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_func,
    input  logic       i_stall,
    input  t_status    i_status,
    output logic       o_stall,
    output logic       o_valid,
    output t_dp_op     o_op
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_op    = DP_NOP;
        o_stall = 1'b1;
        case (r_state)
            S_INIT: begin
                o_op = DP_INIT;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_op = DP_LOAD;
                    case (t_func'(i_func))
                        FUNC_PUT:   n_state = S_PUT;
                        FUNC_HEX:   n_state = S_PUT;
                        FUNC_NL:    n_state = S_NL;
                        FUNC_CLEAR: n_state = S_CLEAR;
                        FUNC_READ:  n_state = S_READ;
                        FUNC_DEC:   n_state = S_DIV_MUL;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                o_op = DP_PUT;
                n_state = i_status.last_cell ? S_SCROLL : S_NEXT;
            end
            S_SCROLL: begin
                o_op = DP_SCROLL;
                if (i_status.scroll_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.chars_left) begin
                    n_state = S_PUT;
                end else if (i_status.nl_pending) begin
                    n_state = S_NL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NL: begin
                o_op = DP_NL;
                n_state = i_status.last_row ? S_SCROLL : S_NEXT;
            end
            S_CLEAR: begin
                o_op = DP_CLEAR;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_op = DP_READ;
                n_state = S_DONE;
            end
            S_DIV_MUL: begin
                if (i_status.dec_done) begin
                    n_state = S_NEXT;
                end else begin
                    o_op = DP_DIV_MUL;
                    n_state = S_DIV_SUB;
                end
            end
            S_DIV_SUB: begin
                o_op = DP_DIV_SUB;
                n_state = S_DIV_MUL;
            end
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    o_op = DP_RESULT;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule

/* design/tcw_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the text console writer: cell memory, cursor, digit logic and result register.
module tcw_datapath import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_op      i_op,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_attribute,
    input  logic [63:0] i_number,
    input  logic [10:0] i_read_index,
    input  logic        i_newline_after,
    output t_status     o_status,
    output logic [15:0] o_read_word,
    output logic [10:0] o_cursor_pos
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam int CNTW = $clog2(CELLS + 1);
    localparam int CLW = $clog2(COLUMNS + 1);
    localparam int RW = $clog2(ROWS + 1);

    logic [15:0]     mem [CELLS];
    logic [15:0]     r_rdata;
    logic [15:0]     r_blank;
    logic [CNTW-1:0] r_cnt;
    logic [AW-1:0]   r_cur;
    logic [CLW-1:0]  r_col;
    logic [RW-1:0]   r_row;
    t_func           r_func;
    logic [7:0]      r_ch;
    logic [7:0]      r_attr;
    logic [63:0]     r_num;
    logic [31:0]     r_v;
    logic [31:0]     r_q;
    logic [3:0]      r_dig [10];
    logic [LEFT_W-1:0] r_left;
    logic            r_nl;
    logic [AW-1:0]   r_ridx;
    logic            r_rd_ok;
    logic [15:0]     r_read_word;
    logic [AW-1:0]   r_cur_out;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [15:0]     wdata;
    logic [7:0]      put_ch;
    logic [LEFT_W-1:0] left_m1;
    logic [63:0]     prod;
    logic [31:0]     q_ten;
    logic [31:0]     dig_full;
    logic [31:0]     ridx_ext;
    logic [31:0]     cur_ext;
    logic [CNTW-1:0] cnt_m1;

    assign ridx_ext = 32'(i_read_index);
    assign cnt_m1   = r_cnt - CNTW'(1);
    assign left_m1  = r_left - LEFT_W'(1);
    assign prod     = 64'(r_v) * 64'(RECIP_TEN);
    assign q_ten    = {r_q[28:0], 3'b000} + {r_q[30:0], 1'b0};
    assign dig_full = r_v - q_ten;

    always_comb begin
        case (r_func)
            FUNC_HEX: begin
                if (r_left == HEX_LEN) begin
                    put_ch = CHAR_ZERO;
                end else if (r_left == HEX_LEN - LEFT_W'(1)) begin
                    put_ch = CHAR_X;
                end else begin
                    put_ch = hex_char(r_num[63:60]);
                end
            end
            FUNC_DEC: put_ch = CHAR_ZERO + {4'b0, r_dig[left_m1[3:0]]};
            default:  put_ch = r_ch;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = r_blank;
        raddr = r_ridx;
        case (i_op)
            DP_INIT: begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = RESET_BLANK;
            end
            DP_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
            end
            DP_PUT: begin
                we    = 1'b1;
                waddr = r_cur;
                wdata = {r_attr, put_ch};
            end
            DP_SCROLL: begin
                if (32'(r_cnt) < 32'(CELLS - COLUMNS)) begin
                    raddr = AW'(32'(r_cnt) + 32'(COLUMNS));
                end else begin
                    raddr = '0;
                end
                if (r_cnt != '0) begin
                    we    = 1'b1;
                    waddr = cnt_m1[AW-1:0];
                    if (32'(r_cnt) <= 32'(CELLS - COLUMNS)) begin
                        wdata = r_rdata;
                    end
                end
            end
            default: begin
                raddr = r_ridx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= RESET_BLANK;
        end else if (i_cfg_we) begin
            r_blank <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cur <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            case (i_op)
                DP_INIT, DP_CLEAR, DP_SCROLL: r_cnt <= r_cnt + CNTW'(1);
                default: r_cnt <= '0;
            endcase
            case (i_op)
                DP_PUT: begin
                    if (r_cur != AW'(CELLS - 1)) begin
                        r_cur <= r_cur + AW'(1);
                        if (r_col == CLW'(COLUMNS - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= r_col + CLW'(1);
                        end
                    end
                end
                DP_NL: begin
                    if (r_row != RW'(ROWS - 1)) begin
                        r_cur <= AW'(32'(r_cur) - 32'(r_col) + 32'(COLUMNS));
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end
                end
                DP_SCROLL: begin
                    if (32'(r_cnt) == 32'(CELLS)) begin
                        r_cur <= AW'(CELLS - COLUMNS);
                        r_col <= '0;
                        r_row <= RW'(ROWS - 1);
                    end
                end
                DP_CLEAR: begin
                    if (32'(r_cnt) == 32'(CELLS - 1)) begin
                        r_cur <= '0;
                        r_col <= '0;
                        r_row <= '0;
                    end
                end
                default: begin
                    r_cur <= r_cur;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_func  <= t_func'(i_func);
                r_ch    <= i_character;
                r_attr  <= i_attribute;
                r_num   <= i_number;
                r_v     <= i_number[31:0];
                r_ridx  <= ridx_ext[AW-1:0];
                r_rd_ok <= ridx_ext < 32'(CELLS);
                case (t_func'(i_func))
                    FUNC_PUT: begin
                        r_left <= LEFT_W'(1);
                        r_nl   <= i_newline_after;
                    end
                    FUNC_HEX: begin
                        r_left <= HEX_LEN;
                        r_nl   <= i_newline_after;
                    end
                    FUNC_DEC: begin
                        r_left <= '0;
                        r_nl   <= i_newline_after;
                    end
                    FUNC_NL: begin
                        r_left <= '0;
                        r_nl   <= 1'b1;
                    end
                    default: begin
                        r_left <= '0;
                        r_nl   <= 1'b0;
                    end
                endcase
            end
            DP_PUT: begin
                r_left <= left_m1;
                if (r_left <= HEX_DIGITS) begin
                    r_num <= {r_num[59:0], 4'b0000};
                end
            end
            DP_NL: begin
                r_nl <= 1'b0;
            end
            DP_DIV_MUL: begin
                r_q <= 32'(prod[63:35]);
            end
            DP_DIV_SUB: begin
                r_dig[r_left[3:0]] <= dig_full[3:0];
                r_left <= r_left + LEFT_W'(1);
                r_v <= r_q;
            end
            DP_RESULT: begin
                r_read_word <= (r_func == FUNC_READ && r_rd_ok) ? r_rdata : 16'h0000;
                r_cur_out   <= r_cur;
            end
            default: begin
                r_nl <= r_nl;
            end
        endcase
    end

    assign cur_ext = 32'(r_cur_out);

    assign o_status.sweep_last  = 32'(r_cnt) == 32'(CELLS - 1);
    assign o_status.scroll_last = 32'(r_cnt) == 32'(CELLS);
    assign o_status.last_cell   = r_cur == AW'(CELLS - 1);
    assign o_status.last_row    = r_row == RW'(ROWS - 1);
    assign o_status.chars_left  = r_func != FUNC_DEC ? r_left != '0 : r_left != '0;
    assign o_status.nl_pending  = r_nl;
    assign o_status.dec_done    = (r_v == 32'd0) || (r_left == DEC_MAX);
    assign o_read_word  = r_read_word;
    assign o_cursor_pos = cur_ext[10:0];

endmodule
